### rtl/linear_probe_hash_table_assert.svh
// Assertion macros shared by the hash table RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define LPHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// Next-cycle implication, held off while in reset.
`define LPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

### rtl/lpht_pkg.sv
// Shared types and codes for the linear probe hash table.
// No dependencies.
package lpht_pkg;

    localparam int REQ_W    = 2;
    localparam int FIELD_W  = 64;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    localparam int HASH_MUL = 31;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_ADD    = 2'd0;
    localparam req_t REQ_SEARCH = 2'd1;
    localparam req_t REQ_DELETE = 2'd2;
    localparam req_t REQ_RSVD   = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_MISS  = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;
    localparam status_t STATUS_EMPTY = 2'd3;

endpackage

### rtl/linear_probe_hash_table.sv
// Open-addressing key-value table with linear probing and tombstones.
// Each request hashes its key byte by byte, issues a read of the home slot, then checks
// probed slots one at a time over the single read port before the response; a refused
// request goes straight to the response. Requests are taken one at a time: in_ready
// rises again after the response is queued into the output register.
// Reset: asynchronous, active low; a clearing pass then wipes every slot, in_ready low.
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_BYTES   = 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [FIELD_W-1:0]  key_bytes,
    input  logic [LEN_W-1:0]    key_len,
    input  logic [FIELD_W-1:0]  phone_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [FIELD_W-1:0]  found_value,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W  = 8 * KEY_BYTES;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [LIVE_W-1:0] LIVE_FULL = LIVE_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(KEY_BYTES);

    // One memory word per slot: flags, key and value side by side
    typedef struct packed {
        logic               used;
        logic               deleted;
        logic [LEN_W-1:0]   len;
        logic [KEY_W-1:0]   key;
        logic [FIELD_W-1:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_CHECK,
        ST_RESP
    } state_t;

    state_t             state_reg,       state_next;
    req_t               req_reg,         req_next;
    logic [KEY_W-1:0]   key_reg,         key_next;
    logic [LEN_W-1:0]   len_reg,         len_next;
    logic [FIELD_W-1:0] value_reg,       value_next;
    logic [ADDR_W-1:0]  p_reg,           p_next;
    logic [ADDR_W-1:0]  probe_cnt_reg,   probe_cnt_next;
    logic [ADDR_W-1:0]  clr_addr_reg,    clr_addr_next;
    logic [LIVE_W-1:0]  live_count_reg,  live_count_next;
    status_t            res_status_reg,  res_status_next;
    logic [FIELD_W-1:0] res_found_reg,   res_found_next;
    logic               out_valid_reg,   out_valid_next;
    status_t            status_reg,      status_next;
    logic [FIELD_W-1:0] found_value_reg, found_value_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;

    // Slot memory: one write and one registered read per cycle
    slot_t             slot_mem [TABLE_DEPTH];
    slot_t             rd_data_reg;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    slot_t             mem_wdata;

    logic [LEN_W-1:0]  len_c;
    logic [KEY_W-1:0]  key_c;
    logic [ADDR_W-1:0] p_inc;
    logic              last_probe;
    logic              slot_free;
    logic              slot_match;
    logic              hash_start;
    logic              hash_done;
    logic [ADDR_W-1:0] hash_home;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

    // Clamp the length and drop stray bytes so that hashing, storing and
    // comparing all see the same canonical key
    assign len_c = (key_len > LEN_MAX) ? LEN_MAX : key_len;

    always_comb
    begin
        for (int j = 0; j < KEY_BYTES; j++)
        begin
            key_c[8*j +: 8] = (LEN_W'(j) < len_c) ? key_bytes[8*j +: 8] : 8'h00;
        end
    end

    // Probe walk wraps at the table end
    assign p_inc      = (p_reg == LAST_SLOT) ? '0 : p_reg + ADDR_W'(1);
    assign last_probe = (probe_cnt_reg == LAST_SLOT);

    // A never-used slot or a tombstone takes an add; a live slot with the
    // same length and bytes is a hit for search and delete
    assign slot_free  = !rd_data_reg.used || rd_data_reg.deleted;
    assign slot_match = rd_data_reg.used && !rd_data_reg.deleted &&
                        (rd_data_reg.len == len_reg) && (rd_data_reg.key == key_reg);

    lpht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg),
        .len   (len_reg),
        .done  (hash_done),
        .home  (hash_home)
    );

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        key_next         = key_reg;
        len_next         = len_reg;
        value_next       = value_reg;
        p_next           = p_reg;
        probe_cnt_next   = probe_cnt_reg;
        clr_addr_next    = clr_addr_reg;
        live_count_next  = live_count_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        status_next      = status_reg;
        found_value_next = found_value_reg;
        entry_count_next = entry_count_reg;
        // Drop the held response once the sink takes it
        out_valid_next   = out_valid_reg && !out_ready;

        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = p_reg;
        mem_waddr  = p_reg;
        mem_wdata  = rd_data_reg;
        hash_start = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Wipe one slot per cycle after reset
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = req_type;
                    key_next       = key_c;
                    len_next       = len_c;
                    value_next     = phone_value;
                    res_found_next = '0;
                    // Refused requests go straight to the response
                    if (req_type == REQ_RSVD)
                    begin
                        res_status_next = STATUS_MISS;
                        state_next      = ST_RESP;
                    end
                    else if (len_c == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_RESP;
                    end
                    else if ((req_type == REQ_ADD) && (live_count_reg == LIVE_FULL))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                if (hash_done)
                begin
                    p_next         = hash_home;
                    probe_cnt_next = '0;
                    state_next     = ST_ISSUE;
                end
            end

            ST_ISSUE:
            begin
                mem_re     = 1'b1;
                mem_raddr  = p_reg;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (req_reg == REQ_ADD)
                begin
                    if (slot_free)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = '{used: 1'b1, deleted: 1'b0, len: len_reg,
                                            key: key_reg, value: value_reg};
                        live_count_next = live_count_reg + LIVE_W'(1);
                        res_status_next = STATUS_OK;
                        state_next      = ST_RESP;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        p_next         = p_inc;
                        probe_cnt_next = probe_cnt_reg + ADDR_W'(1);
                        mem_re         = 1'b1;
                        mem_raddr      = p_inc;
                    end
                end
                else
                begin
                    if (!rd_data_reg.used)
                    begin
                        res_status_next = STATUS_MISS;
                        state_next      = ST_RESP;
                    end
                    else if (slot_match)
                    begin
                        res_status_next = STATUS_OK;
                        state_next      = ST_RESP;
                        if (req_reg == REQ_SEARCH)
                        begin
                            res_found_next = rd_data_reg.value;
                        end
                        else
                        begin
                            // Leave a tombstone in place
                            mem_we            = 1'b1;
                            mem_wdata.deleted = 1'b1;
                            if (live_count_reg != '0)
                            begin
                                live_count_next = live_count_reg - LIVE_W'(1);
                            end
                        end
                    end
                    else if (last_probe)
                    begin
                        res_status_next = STATUS_MISS;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        p_next         = p_inc;
                        probe_cnt_next = probe_cnt_reg + ADDR_W'(1);
                        mem_re         = 1'b1;
                        mem_raddr      = p_inc;
                    end
                end
            end

            ST_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    found_value_next = res_found_reg;
                    entry_count_next = COUNT_W'(live_count_reg);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            req_reg         <= REQ_ADD;
            key_reg         <= '0;
            len_reg         <= '0;
            value_reg       <= '0;
            p_reg           <= '0;
            probe_cnt_reg   <= '0;
            clr_addr_reg    <= '0;
            live_count_reg  <= '0;
            res_status_reg  <= STATUS_OK;
            res_found_reg   <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            found_value_reg <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            key_reg         <= key_next;
            len_reg         <= len_next;
            value_reg       <= value_next;
            p_reg           <= p_next;
            probe_cnt_reg   <= probe_cnt_next;
            clr_addr_reg    <= clr_addr_next;
            live_count_reg  <= live_count_next;
            res_status_reg  <= res_status_next;
            res_found_reg   <= res_found_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            found_value_reg <= found_value_next;
            entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    `LPHT_ASSERT_NOW(a_idle_no_hash, in_ready, !hash_done)
    `LPHT_ASSERT_NOW(a_live_bound, 1'b1, live_count_reg <= LIVE_FULL)
    `LPHT_ASSERT_NOW(a_live_on_write, live_count_next != live_count_reg, mem_we && state_reg == ST_CHECK)
    `LPHT_ASSERT_NEXT(a_resp_delivers, state_reg == ST_RESP && (!out_valid_reg || out_ready), out_valid_reg)

endmodule

### rtl/lpht_hash.sv
// Byte-serial polynomial hash: h = (h * 31 + byte) mod TABLE_DEPTH.
// Depends on lpht_pkg and linear_probe_hash_table_assert.svh.
`include "linear_probe_hash_table_assert.svh"

module lpht_hash
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_BYTES   = 8
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [8*KEY_BYTES-1:0]            key,
    input  logic [LEN_W-1:0]                  len,
    output logic                              done,
    output logic [$clog2(TABLE_DEPTH)-1:0]    home
);

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int BIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int MAX_SUM   = HASH_MUL * (TABLE_DEPTH - 1) + 255;
    localparam int SUM_W     = $clog2(MAX_SUM + 1);
    localparam int RED_STEPS = $clog2(MAX_SUM / TABLE_DEPTH + 1);

    logic              busy_reg;
    logic [BIDX_W-1:0] idx_reg;
    logic [ADDR_W-1:0] h_reg;

    logic [7:0]        cur_byte;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  acc;
    logic [ADDR_W-1:0] h_next;
    logic              last;

    // Multiply-accumulate, then a short restoring reduction by the depth
    always_comb
    begin
        cur_byte = key[8*idx_reg +: 8];
        sum      = SUM_W'(h_reg) * SUM_W'(HASH_MUL) + SUM_W'(cur_byte);
        acc      = sum;
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (acc >= (SUM_W'(TABLE_DEPTH) << k))
            begin
                acc = acc - (SUM_W'(TABLE_DEPTH) << k);
            end
        end
        h_next = ADDR_W'(acc);
    end

    assign last = ((LEN_W'(idx_reg) + LEN_W'(1)) == len);
    assign done = busy_reg && last;
    assign home = h_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            h_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            h_reg    <= '0;
        end
        else if (busy_reg)
        begin
            h_reg   <= h_next;
            idx_reg <= idx_reg + BIDX_W'(1);
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    `LPHT_ASSERT_NOW(a_hash_start_idle, start, !busy_reg)
    `LPHT_ASSERT_NOW(a_hash_home_range, done, home <= ADDR_W'(TABLE_DEPTH - 1))
    `LPHT_ASSERT_NEXT(a_hash_keeps_busy, busy_reg && !done, busy_reg)

endmodule
